// ===== sv/lkvt_pkg.sv =====
// ---------------------------------------------------------------------------
// Linear key/value table package
// Sizes, request and result layouts, and operation and status codes shared
// by the table and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package lkvt_pkg;

  // Table geometry.
  localparam int CAPACITY   = 128;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  // Operation codes carried in a request.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [7:0]  entry_total;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/lkvt_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/linear_key_value_table.sv =====
// ---------------------------------------------------------------------------
// Linear key/value table
// Unsorted, packed table of key/value pairs searched one slot per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   A request (type, key, value) is taken at a clock edge where start is high
//   and busy is low. Exactly one result follows: it sits on the result port
//   for a single cycle while done is high, and it cannot be held off.
//   Insert appends without a duplicate check and answers in the cycle after
//   the request (table full gives the full status). Update, remove and
//   search scan the key store from slot 0 upwards, one key compare per
//   cycle through a single comparator fed from the registered key RAM port.
//   An update that hits answers from the fetch state; a search or remove
//   that hits answers from the finish state, since it needs a further RAM
//   read; a miss answers once the last stored key has been compared. busy
//   stays high meanwhile. A search, update or remove on an empty table
//   answers a miss in the cycle after the request. Remove moves the last
//   entry into the matched slot. Reset clears the entry count and the
//   control state; the stores need no clearing since a slot is always
//   written before it becomes part of the table.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire lkvt_pkg::req_t request,
  output logic                done,
  output lkvt_pkg::rsp_t      result
);

  import lkvt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FETCH  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]            state;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   idx;
  logic                  cmp_valid;
  logic [IDX_BITS-1:0]   cmp_idx;
  logic [IDX_BITS-1:0]   slot;
  req_t                  req_q;

  logic                  accept;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_value;
  logic [IDX_BITS-1:0]   last_idx;
  logic                  key_hit;

  logic                  key_we;
  logic [IDX_BITS-1:0]   key_waddr;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [IDX_BITS-1:0]   key_raddr;
  logic [KEY_BITS-1:0]   key_rd;
  logic                  val_we;
  logic [IDX_BITS-1:0]   val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [IDX_BITS-1:0]   val_raddr;
  logic [VALUE_BITS-1:0] val_rd;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_key   = KEY_BITS'(request.key);
  assign in_value = VALUE_BITS'(request.value);
  assign q_key    = KEY_BITS'(req_q.key);
  assign q_value  = VALUE_BITS'(req_q.value);
  assign last_idx = IDX_BITS'(count - 1'b1);

  // The shared comparator: stored key against the requested key.
  assign key_hit = (key_rd == q_key);

  // Storage write and read steering.
  always_comb begin
    key_we    = 1'b0;
    key_waddr = slot;
    key_wdata = key_rd;
    val_we    = 1'b0;
    val_waddr = slot;
    val_wdata = val_rd;
    key_raddr = idx[IDX_BITS-1:0];
    val_raddr = slot;
    unique case (state)
      S_IDLE: begin
        if (accept && request.req_type == OP_INSERT &&
            count < CNT_BITS'(CAPACITY)) begin
          key_we    = 1'b1;
          key_waddr = IDX_BITS'(count);
          key_wdata = in_key;
          val_we    = 1'b1;
          val_waddr = IDX_BITS'(count);
          val_wdata = in_value;
        end
      end
      S_SCAN: begin
        key_raddr = idx[IDX_BITS-1:0];
      end
      S_FETCH: begin
        key_raddr = last_idx;
        if (req_q.req_type == OP_REMOVE) begin
          val_raddr = last_idx;
        end
        if (req_q.req_type == OP_UPDATE) begin
          val_we    = 1'b1;
          val_wdata = q_value;
        end
      end
      S_FINISH: begin
        if (req_q.req_type == OP_REMOVE) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end
      end
      default: begin
        key_raddr = idx[IDX_BITS-1:0];
      end
    endcase
  end

  lkvt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  lkvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rd)
  );

  // Sequencer: accept, scan one key per cycle, then act on the hit or report the miss.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_q     <= request;
            idx       <= '0;
            cmp_valid <= 1'b0;
            if (request.req_type == OP_INSERT) begin
              done               <= 1'b1;
              result.found_value <= '0;
              if (count < CNT_BITS'(CAPACITY)) begin
                count              <= count + 1'b1;
                result.status      <= ST_OK;
                result.entry_total <= 8'(count + 1'b1);
              end else begin
                result.status      <= ST_FULL;
                result.entry_total <= 8'(count);
              end
            end else if (count == '0) begin
              done               <= 1'b1;
              result.status      <= ST_MISS;
              result.found_value <= '0;
              result.entry_total <= 8'(count);
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue the next read while the previous key is compared.
          if (idx < count) begin
            idx <= idx + 1'b1;
          end
          cmp_valid <= (idx < count);
          cmp_idx   <= idx[IDX_BITS-1:0];
          if (cmp_valid && key_hit) begin
            slot  <= cmp_idx;
            state <= S_FETCH;
          end else if (cmp_valid && cmp_idx == last_idx) begin
            done               <= 1'b1;
            result.status      <= ST_MISS;
            result.found_value <= '0;
            result.entry_total <= 8'(count);
            state              <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (req_q.req_type == OP_UPDATE) begin
            done               <= 1'b1;
            result.status      <= ST_OK;
            result.found_value <= '0;
            result.entry_total <= 8'(count);
            state              <= S_IDLE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done          <= 1'b1;
          result.status <= ST_OK;
          state         <= S_IDLE;
          if (req_q.req_type == OP_REMOVE) begin
            count              <= count - 1'b1;
            result.found_value <= '0;
            result.entry_total <= 8'(count - 1'b1);
          end else begin
            result.found_value <= 32'(val_rd);
            result.entry_total <= 8'(count);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/lkvt_checker.sv =====
// ---------------------------------------------------------------------------
// Linear key/value table checker
// Port-level properties of the request/result sequence, bound to the table.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvt_assertions (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire lkvt_pkg::rsp_t result
);

  import lkvt_pkg::*;

  // A taken request either answers at once or holds the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("request taken but neither busy nor answered");

  // Leaving the busy phase always delivers a result.
  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // A full status only appears on a table that is really full.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.entry_total == 8'(CAPACITY))
    else $error("full status with spare room");

  // Failed requests never report a value.
  a_no_value_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.found_value == '0)
    else $error("value reported on a failed request");

  // Status codes stay within the defined set.
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status == ST_OK || result.status == ST_MISS ||
             result.status == ST_FULL)
    else $error("undefined status code");

endmodule

bind linear_key_value_table lkvt_assertions u_lkvt_assertions (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
